>>> sv/matrix4_multiply_accumulate_assert.svh
// Assertion macros shared by the matrix multiply-accumulate RTL.
// They sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef MATRIX4_MULTIPLY_ACCUMULATE_ASSERT_SVH
`define MATRIX4_MULTIPLY_ACCUMULATE_ASSERT_SVH

// The consequence must hold in the same cycle as the condition.
`define M4MA_ASSERT_IMP(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
    else $error(msg);

// The consequence must hold in the cycle after the condition.
`define M4MA_ASSERT_NEXT(lbl, pre, post, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
    else $error(msg);

`endif

>>> sv/m4ma_pkg.sv
package m4ma_pkg;

  // Default geometry and number format.
  localparam int DIMENSION     = 4;
  localparam int FRACTION_BITS = 16;
  localparam int DATA_W        = 32;

  // Configuration port.
  localparam int CFG_AW = 3;
  localparam logic REG_ACCUMULATE_MODE = 1'b0;
  localparam logic ACC_MODE_RESET      = 1'b1;

  // Input request commands.
  localparam logic CMD_ELEMENT  = 1'b0;
  localparam logic CMD_IDENTITY = 1'b1;

  // One input request.
  typedef struct packed {
    logic                     command;
    logic signed [DATA_W-1:0] element_value;
  } in_req_t;

  // One result request.
  typedef struct packed {
    logic signed [DATA_W-1:0] product_value;
    logic [1:0]               row_index;
    logic [1:0]               column_index;
    logic                     saturated;
    logic                     last_element;
  } out_rsp_t;

  // Control that travels with each token along the cell chain.
  typedef struct packed {
    logic valid;
    logic first;
    logic last;
  } tok_ctl_t;

  // Control for the current-matrix shift line.
  typedef struct packed {
    logic shift;
    logic wr;
    logic ident;
  } line_ctl_t;

endpackage

>>> sv/m4ma_cell.sv
module m4ma_cell #(
  parameter int DIMENSION = m4ma_pkg::DIMENSION
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            adv,
  input  m4ma_pkg::tok_ctl_t              ctl_in,
  input  logic signed [m4ma_pkg::DATA_W-1:0] a_in,
  input  logic [$clog2(DIMENSION)-1:0]    k_in,
  input  logic                            op_we,
  input  logic [$clog2(DIMENSION)-1:0]    op_idx,
  input  logic signed [m4ma_pkg::DATA_W-1:0] op_data,
  output m4ma_pkg::tok_ctl_t              ctl_out,
  output logic signed [m4ma_pkg::DATA_W-1:0] a_out,
  output logic [$clog2(DIMENSION)-1:0]    k_out,
  output logic                            res_valid,
  output logic signed [2*m4ma_pkg::DATA_W+$clog2(DIMENSION)-1:0] res_acc
);

  localparam int KW = $clog2(DIMENSION);
  localparam int PW = 2 * m4ma_pkg::DATA_W;
  localparam int AW = PW + KW;

  // One operand column, indexed by operand row.
  logic signed [m4ma_pkg::DATA_W-1:0] op_r [DIMENSION];

  m4ma_pkg::tok_ctl_t                 ctl_r;
  logic signed [m4ma_pkg::DATA_W-1:0] a_r;
  logic [KW-1:0]                      k_r;
  m4ma_pkg::tok_ctl_t                 pctl_r;
  logic signed [PW-1:0]               p_r;
  logic signed [PW-1:0]               p_nxt;
  logic signed [AW-1:0]               acc_r;
  logic signed [AW-1:0]               acc_nxt;
  logic                               res_v_r;

  // Operand column store, written while the block loads elements.
  always_ff @(posedge clk) begin
    if (op_we) begin
      op_r[op_idx] <= op_data;
    end
  end

  // Product of the passing current-matrix element with this column's entry.
  assign p_nxt = a_r * op_r[k_r];

  // Running dot product, restarted on the first term of each row.
  assign acc_nxt = (pctl_r.first ? AW'(0) : acc_r) + AW'(p_r);

  // Control pipeline: token hop, product stage, result flag.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ctl_r   <= '0;
      pctl_r  <= '0;
      res_v_r <= 1'b0;
    end else if (adv) begin
      ctl_r   <= ctl_in;
      pctl_r  <= ctl_r;
      res_v_r <= pctl_r.valid & pctl_r.last;
    end
  end

  // Data pipeline.
  always_ff @(posedge clk) begin
    if (adv) begin
      a_r <= a_in;
      k_r <= k_in;
      p_r <= p_nxt;
      if (pctl_r.valid) begin
        acc_r <= acc_nxt;
      end
    end
  end

  assign ctl_out   = ctl_r;
  assign a_out     = a_r;
  assign k_out     = k_r;
  assign res_valid = res_v_r;
  assign res_acc   = acc_r;

endmodule

>>> sv/m4ma_line.sv
module m4ma_line #(
  parameter int DIMENSION     = m4ma_pkg::DIMENSION,
  parameter int FRACTION_BITS = m4ma_pkg::FRACTION_BITS
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  m4ma_pkg::line_ctl_t                   ctl,
  input  logic [$clog2(DIMENSION*DIMENSION)-1:0] widx,
  input  logic signed [m4ma_pkg::DATA_W-1:0]    wdata,
  output logic signed [m4ma_pkg::DATA_W-1:0]    head
);

  localparam int N  = DIMENSION * DIMENSION;
  localparam int LW = $clog2(N);

  // Current matrix as a rotating line; stage 0 is the read tap.
  logic signed [m4ma_pkg::DATA_W-1:0] line_r   [N];
  logic signed [m4ma_pkg::DATA_W-1:0] line_nxt [N];

  for (genvar s = 0; s < N; s++) begin : g_stage
    localparam int NEXT_S = (s + 1) % N;
    localparam logic signed [m4ma_pkg::DATA_W-1:0] ID_VAL =
      ((s % DIMENSION) == (s / DIMENSION)) ?
      (m4ma_pkg::DATA_W'(1) <<< FRACTION_BITS) : '0;

    // Identity load, product write-back, rotation, or hold.
    always_comb begin
      if (ctl.ident) begin
        line_nxt[s] = ID_VAL;
      end else if (ctl.wr && (widx == LW'(s))) begin
        line_nxt[s] = wdata;
      end else if (ctl.shift) begin
        line_nxt[s] = line_r[NEXT_S];
      end else begin
        line_nxt[s] = line_r[s];
      end
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        line_r[s] <= ID_VAL;
      end else begin
        line_r[s] <= line_nxt[s];
      end
    end
  end

  assign head = line_r[0];

endmodule

>>> sv/matrix4_multiply_accumulate.sv
// Fixed-point matrix multiply-accumulate. The block holds a current
// DIMENSION x DIMENSION matrix in signed Q(32-FRACTION_BITS).FRACTION_BITS,
// identity after reset or after an identity command. Operand elements are
// accepted one per cycle in row-major order; the last one starts the product
// current x operand, and input stays stalled until the final product element
// has entered the output register. The product runs on a chain of DIMENSION
// multiply-accumulate cells, one per product column, fed by the current
// matrix rotating out of a shift line one element per cycle while the output
// is not stalled. Results leave in row-major order, each the exact sum shifted
// right by FRACTION_BITS and saturated to 32 bits. With accumulate_mode set
// (the reset value) the product also becomes the new current matrix. Register
// accumulate_mode sits at byte address 0.
module matrix4_multiply_accumulate #(
  parameter int DIMENSION     = m4ma_pkg::DIMENSION,
  parameter int FRACTION_BITS = m4ma_pkg::FRACTION_BITS
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  m4ma_pkg::in_req_t            in_req,
  output logic                         out_valid,
  input  logic                         out_ready,
  output m4ma_pkg::out_rsp_t           out_rsp,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [m4ma_pkg::CFG_AW-1:0]  paddr,
  input  logic [31:0]                  pwdata,
  output logic [31:0]                  prdata,
  output logic                         pready
);

  `include "matrix4_multiply_accumulate_assert.svh"

  localparam int DW    = m4ma_pkg::DATA_W;
  localparam int KW    = $clog2(DIMENSION);
  localparam int NCELL = DIMENSION * DIMENSION;
  localparam int LW    = $clog2(NCELL);
  localparam int AW    = 2 * DW + KW;
  localparam logic [KW-1:0] LAST_K = KW'(DIMENSION - 1);
  localparam logic [LW-1:0] LAST_W = LW'(NCELL - 1);
  localparam logic signed [AW-1:0] MAX_V = AW'(64'sh0000_0000_7FFF_FFFF);
  localparam logic signed [AW-1:0] MIN_V = ~MAX_V;

  // Configuration register.
  logic acc_mode_r;
  logic cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_mode_r <= m4ma_pkg::ACC_MODE_RESET;
    end else if (cfg_wr && (paddr[m4ma_pkg::CFG_AW-1] == m4ma_pkg::REG_ACCUMULATE_MODE)) begin
      acc_mode_r <= pwdata[0];
    end
  end

  assign prdata = (paddr[m4ma_pkg::CFG_AW-1] == m4ma_pkg::REG_ACCUMULATE_MODE) ?
                  {31'b0, acc_mode_r} : '0;

  // Input side.
  logic          busy_r;
  logic          busy_nxt;
  logic          in_acc;
  logic          op_acc;
  logic          ident_cmd;
  logic          in_last;
  logic [KW-1:0] in_col_r;
  logic [KW-1:0] in_row_r;

  assign in_ready  = !busy_r;
  assign in_acc    = in_valid & in_ready;
  assign op_acc    = in_acc & (in_req.command == m4ma_pkg::CMD_ELEMENT);
  assign ident_cmd = in_acc & (in_req.command == m4ma_pkg::CMD_IDENTITY);
  assign in_last   = op_acc & (in_col_r == LAST_K) & (in_row_r == LAST_K);

  // Element position within the operand matrix.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else if (ident_cmd) begin
      in_col_r <= '0;
      in_row_r <= '0;
    end else if (op_acc) begin
      if (in_col_r == LAST_K) begin
        in_col_r <= '0;
        in_row_r <= (in_row_r == LAST_K) ? '0 : KW'(in_row_r + 1'b1);
      end else begin
        in_col_r <= KW'(in_col_r + 1'b1);
      end
    end
  end

  // Pipeline advance: everything downstream moves when the output can take.
  logic out_valid_r;
  logic adv;

  assign adv = !out_valid_r | out_ready;

  // Feeder: walks the current matrix in row-major order.
  logic          fd_active_r;
  logic [KW-1:0] fk_r;
  logic [KW-1:0] fr_r;
  logic          fd_step;

  assign fd_step = adv & fd_active_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd_active_r <= 1'b0;
      fk_r        <= '0;
      fr_r        <= '0;
    end else if (in_last) begin
      fd_active_r <= 1'b1;
      fk_r        <= '0;
      fr_r        <= '0;
    end else if (fd_step) begin
      if (fk_r == LAST_K) begin
        fk_r <= '0;
        fr_r <= KW'(fr_r + 1'b1);
        if (fr_r == LAST_K) begin
          fd_active_r <= 1'b0;
        end
      end else begin
        fk_r <= KW'(fk_r + 1'b1);
      end
    end
  end

  // Cell chain.
  m4ma_pkg::tok_ctl_t        chain_ctl [DIMENSION+1];
  logic signed [DW-1:0]      chain_a   [DIMENSION+1];
  logic [KW-1:0]             chain_k   [DIMENSION+1];
  logic [DIMENSION-1:0]      res_v;
  logic signed [AW-1:0]      res_acc   [DIMENSION];
  logic signed [DW-1:0]      line_head;

  assign chain_ctl[0].valid = fd_active_r;
  assign chain_ctl[0].first = (fk_r == '0);
  assign chain_ctl[0].last  = (fk_r == LAST_K);
  assign chain_a[0]         = line_head;
  assign chain_k[0]         = fk_r;

  for (genvar c = 0; c < DIMENSION; c++) begin : g_cell
    m4ma_cell #(
      .DIMENSION (DIMENSION)
    ) u_cell (
      .clk       (clk),
      .rst_n     (rst_n),
      .adv       (adv),
      .ctl_in    (chain_ctl[c]),
      .a_in      (chain_a[c]),
      .k_in      (chain_k[c]),
      .op_we     (op_acc && (in_col_r == KW'(c))),
      .op_idx    (in_row_r),
      .op_data   (in_req.element_value),
      .ctl_out   (chain_ctl[c+1]),
      .a_out     (chain_a[c+1]),
      .k_out     (chain_k[c+1]),
      .res_valid (res_v[c]),
      .res_acc   (res_acc[c])
    );
  end

  // At most one cell finishes per cycle; pick it and saturate.
  logic                 sel_v;
  logic signed [AW-1:0] sel_acc;
  logic signed [AW-1:0] sel_sh;
  logic                 sat_hi;
  logic                 sat_lo;
  logic signed [DW-1:0] sat_val;

  assign sel_v = |res_v;

  always_comb begin
    sel_acc = '0;
    for (int c = 0; c < DIMENSION; c++) begin
      if (res_v[c]) begin
        sel_acc = sel_acc | res_acc[c];
      end
    end
  end

  assign sel_sh  = sel_acc >>> FRACTION_BITS;
  assign sat_hi  = sel_sh > MAX_V;
  assign sat_lo  = sel_sh < MIN_V;
  assign sat_val = sat_hi ? MAX_V[DW-1:0] : (sat_lo ? MIN_V[DW-1:0] : sel_sh[DW-1:0]);

  // Output register and product position.
  m4ma_pkg::out_rsp_t out_rsp_r;
  m4ma_pkg::out_rsp_t rsp_nxt;
  logic [KW-1:0]      ocol_r;
  logic [KW-1:0]      orow_r;
  logic               load;

  assign load = adv & sel_v;

  always_comb begin
    rsp_nxt.product_value = sat_val;
    rsp_nxt.row_index     = 2'(orow_r);
    rsp_nxt.column_index  = 2'(ocol_r);
    rsp_nxt.saturated     = sat_hi | sat_lo;
    rsp_nxt.last_element  = (orow_r == LAST_K) && (ocol_r == LAST_K);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      ocol_r      <= '0;
      orow_r      <= '0;
    end else begin
      if (adv) begin
        out_valid_r <= sel_v;
      end
      if (load) begin
        if (ocol_r == LAST_K) begin
          ocol_r <= '0;
          orow_r <= (orow_r == LAST_K) ? '0 : KW'(orow_r + 1'b1);
        end else begin
          ocol_r <= KW'(ocol_r + 1'b1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_rsp_r <= rsp_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_rsp   = out_rsp_r;

  // Busy from the last operand element to the last product element.
  always_comb begin
    busy_nxt = busy_r;
    if (in_last) begin
      busy_nxt = 1'b1;
    end else if (load && rsp_nxt.last_element) begin
      busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else begin
      busy_r <= busy_nxt;
    end
  end

  // Write-back position: where the next product's old element sits in the
  // rotating line. Writes move it forward, rotation moves it back.
  logic [LW-1:0]       wpos_r;
  logic [LW-1:0]       wpos_nxt;
  logic [LW-1:0]       wpos_dec;
  logic [LW-1:0]       wpos_inc;
  logic [LW-1:0]       widx;
  m4ma_pkg::line_ctl_t line_ctl;

  assign wpos_dec = (wpos_r == '0) ? LAST_W : LW'(wpos_r - 1'b1);
  assign wpos_inc = (wpos_r == LAST_W) ? '0 : LW'(wpos_r + 1'b1);
  assign widx     = fd_step ? wpos_dec : wpos_r;

  always_comb begin
    wpos_nxt = wpos_r;
    if (load && !fd_step) begin
      wpos_nxt = wpos_inc;
    end else if (!load && fd_step) begin
      wpos_nxt = wpos_dec;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wpos_r <= '0;
    end else begin
      wpos_r <= wpos_nxt;
    end
  end

  assign line_ctl.shift = fd_step;
  assign line_ctl.wr    = load & acc_mode_r;
  assign line_ctl.ident = ident_cmd;

  m4ma_line #(
    .DIMENSION     (DIMENSION),
    .FRACTION_BITS (FRACTION_BITS)
  ) u_line (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (line_ctl),
    .widx  (widx),
    .wdata (sat_val),
    .head  (line_head)
  );

  // Checks on sequencing between feeder, cells, output and write-back.
  `M4MA_ASSERT_IMP(a_no_input_while_feeding, fd_active_r, !in_ready, "input taken during compute")
  `M4MA_ASSERT_IMP(a_one_cell_result, 1'b1, $onehot0(res_v), "two cells finished together")
  `M4MA_ASSERT_NEXT(a_last_frees_input, load && rsp_nxt.last_element, !busy_r, "busy after last")
  `M4MA_ASSERT_IMP(a_wpos_home_idle, !busy_r, wpos_r == '0, "write position off while idle")

endmodule
